// ===== sv/dct2d_pkg.sv =====
// ----------------------------------------------------------------------------
// DCT-II package
// Frame length, field widths, the quarter-wave cosine ROM and shared types
// for the direct 1-D DCT-II block.
// ----------------------------------------------------------------------------
package dct2d_pkg;

	localparam int FRAME_LENGTH = 64;

	localparam int K_W = $clog2(FRAME_LENGTH);
	localparam int M_W = $clog2(4 * FRAME_LENGTH);
	localparam int J_W = $clog2(FRAME_LENGTH + 1);

	localparam int SAMPLE_W = 16;
	localparam int COS_W = 16;
	localparam int PROD_W = SAMPLE_W + COS_W + 1;
	localparam int ACC_W = 48;
	localparam int SCALE_W = 16;
	localparam int COEF_W = 32;
	localparam int COEF_INDEX_W = 6;
	localparam int COS_FRAC = 15;
	localparam int SCALE_FRAC = 12;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd4096;

	localparam longint unsigned PI_Q30 = 64'd3373259426;
	localparam longint unsigned ONE_Q30 = 64'd1073741824;
	localparam int TAYLOR_TERMS = 8;

	typedef longint unsigned taylor_div_t [1:TAYLOR_TERMS];
	localparam taylor_div_t TAYLOR_DIV = '{64'd2, 64'd12, 64'd30, 64'd56,
		64'd90, 64'd132, 64'd182, 64'd240};

	typedef logic [COS_W-1:0] cos_rom_t [0:FRAME_LENGTH];
	typedef logic [COEF_INDEX_W-1:0] coef_index_t;

	typedef struct packed {
		logic        valid;
		logic        last;
		coef_index_t index;
	} coef_tag_t;

	// Entry j holds cos(pi*j/(2N)) in Q1.15 from a Q2.30 Taylor series.
	function automatic cos_rom_t build_cos_rom();
		cos_rom_t        rom;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint signed   sum;
		longint signed   r;
		for (int j = 0; j <= FRAME_LENGTH; j++) begin
			x = (PI_Q30 * 64'(j)) / (2 * FRAME_LENGTH);
			x2 = (x * x) >> 30;
			term = ONE_Q30;
			sum = longint'(ONE_Q30);
			for (int i = 1; i <= TAYLOR_TERMS; i++) begin
				term = ((term * x2) >> 30) / TAYLOR_DIV[i];
				if (i[0]) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			r = (sum + 16384) >>> 15;
			if (r > 32767) begin
				r = 32767;
			end
			rom[j] = COS_W'(r);
		end
		return rom;
	endfunction

	localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

// ===== sv/dct2d_scale_round.sv =====
// ----------------------------------------------------------------------------
// DCT-II output scaler
// Multiplies a finished sum by the Q4.12 gain in two partial products,
// rounds half up and saturates to a signed 32-bit coefficient.
// ----------------------------------------------------------------------------
module dct2d_scale_round (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic signed [dct2d_pkg::ACC_W-1:0]        acc,
	input  dct2d_pkg::coef_tag_t                      tag,
	input  logic [dct2d_pkg::SCALE_W-1:0]             scale,
	output logic                                      coef_valid,
	output logic signed [dct2d_pkg::COEF_W-1:0]       coefficient,
	output logic [dct2d_pkg::COEF_INDEX_W-1:0]        coef_index,
	output logic                                      last_coef
);

	localparam int LO_W = dct2d_pkg::ACC_W / 2;
	localparam int HI_W = dct2d_pkg::ACC_W - LO_W;
	localparam int PP_LO_W = LO_W + dct2d_pkg::SCALE_W;
	localparam int PP_HI_W = HI_W + dct2d_pkg::SCALE_W + 1;
	localparam int TOTAL_W = dct2d_pkg::ACC_W + dct2d_pkg::SCALE_W;
	localparam int FRAC_W = dct2d_pkg::COS_FRAC + dct2d_pkg::SCALE_FRAC;
	localparam int QUO_W = TOTAL_W - FRAC_W;
	localparam int COEF_W = dct2d_pkg::COEF_W;

	localparam logic signed [TOTAL_W-1:0] ROUND_HALF = TOTAL_W'(1) <<< (FRAC_W - 1);
	localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

	logic [PP_LO_W-1:0]         pp_lo_s1;
	logic signed [PP_HI_W-1:0]  pp_hi_s1;
	logic signed [TOTAL_W-1:0]  total_s2;
	dct2d_pkg::coef_tag_t       tag_s1;
	dct2d_pkg::coef_tag_t       tag_s2;
	logic signed [TOTAL_W-1:0]  rounded;
	logic [QUO_W-1:0]           quo;
	logic signed [COEF_W-1:0]   coef_sat;

	always_comb begin
		rounded = total_s2 + ROUND_HALF;
		quo = rounded[TOTAL_W-1:FRAC_W];
		if (quo[QUO_W-1:COEF_W-1] == '0 || quo[QUO_W-1:COEF_W-1] == '1) begin
			coef_sat = quo[COEF_W-1:0];
		end else if (quo[QUO_W-1]) begin
			coef_sat = COEF_MIN;
		end else begin
			coef_sat = COEF_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			coef_valid <= 1'b0;
		end else begin
			tag_s1 <= tag;
			tag_s2 <= tag_s1;
			coef_valid <= tag_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		pp_lo_s1 <= PP_LO_W'(acc[LO_W-1:0]) * PP_LO_W'(scale);
		pp_hi_s1 <= PP_HI_W'($signed(acc[dct2d_pkg::ACC_W-1:LO_W]))
			* PP_HI_W'($signed({1'b0, scale}));
		total_s2 <= (TOTAL_W'(pp_hi_s1) <<< LO_W) + TOTAL_W'(pp_lo_s1);
		coefficient <= coef_sat;
		coef_index <= tag_s2.index;
		last_coef <= tag_s2.last;
	end

endmodule

// ===== sv/dct2_direct_1d.sv =====
// ----------------------------------------------------------------------------
// Direct 1-D DCT-II
// Stores a frame of samples, then computes every coefficient as a dot
// product with a cosine row on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Usage:
// An item (one sample) is taken at a clock edge with start high and busy
// low. Samples of a frame are taken one per cycle while the block is idle.
// The item that completes a frame of N = 64 samples raises busy, and the
// block then issues N*N multiply-accumulates, one per cycle, through a
// single 16x17 multiplier fed by the sample memory and the cosine ROM.
// Coefficients leave in order of k after the last sample, one strobe
// cycle each on coef_valid, with coef_index = k and last_coef
// on k = N-1; busy falls after that final strobe, and no sample of the
// next frame is taken until then.
// The receiver cannot stall: every strobed coefficient must be taken.
// The gain is written on the cfg channel, which is ready only while idle.
// Reset clears the fill count, the sequencer and sets the gain to 1.0;
// the sample memory is not cleared.
// ----------------------------------------------------------------------------
module dct2_direct_1d (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      start,
	output logic                                      busy,
	input  logic signed [dct2d_pkg::SAMPLE_W-1:0]     sample,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [dct2d_pkg::SCALE_W-1:0]             cfg_data,
	output logic                                      coef_valid,
	output logic signed [dct2d_pkg::COEF_W-1:0]       coefficient,
	output logic [dct2d_pkg::COEF_INDEX_W-1:0]        coef_index,
	output logic                                      last_coef
);

	localparam int K_W = dct2d_pkg::K_W;
	localparam int M_W = dct2d_pkg::M_W;
	localparam int J_W = dct2d_pkg::J_W;
	localparam int N = dct2d_pkg::FRAME_LENGTH;

	localparam logic [K_W-1:0] LAST_IDX = K_W'(N - 1);
	localparam logic [M_W-1:0] ONE_N = M_W'(N);
	localparam logic [M_W-1:0] TWO_N = M_W'(2 * N);
	localparam logic [M_W-1:0] THREE_N = M_W'(3 * N);
	localparam logic [M_W:0] FOUR_N = (M_W + 1)'(4 * N);

	typedef enum logic [1:0] {
		ST_FILL,
		ST_ISSUE,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic                   valid;
		logic                   first;
		logic                   last;
		dct2d_pkg::coef_index_t index;
	} mac_tag_t;

	state_t state_q;
	logic [K_W-1:0] fill_q;
	logic [K_W-1:0] k_q;
	logic [K_W-1:0] n_q;
	logic [M_W-1:0] m_q;
	logic [M_W-1:0] step_q;
	logic [dct2d_pkg::SCALE_W-1:0] scale_q;

	logic signed [dct2d_pkg::SAMPLE_W-1:0] store_mem [0:N-1];

	logic signed [dct2d_pkg::SAMPLE_W-1:0] sample_s1;
	logic signed [dct2d_pkg::COS_W:0]      cos_s1;
	mac_tag_t                              tag_s1;
	logic signed [dct2d_pkg::PROD_W-1:0]   prod_s2;
	mac_tag_t                              tag_s2;
	logic signed [dct2d_pkg::ACC_W-1:0]    acc_q;
	logic signed [dct2d_pkg::ACC_W-1:0]    done_acc_q;
	dct2d_pkg::coef_tag_t                  done_tag_q;

	logic [M_W:0]   m_sum;
	logic [M_W:0]   m_wrap;
	logic [M_W-1:0] k_inc;
	logic [J_W-1:0] j_sel;
	logic           neg_sel;
	logic [dct2d_pkg::COS_W-1:0]          cos_mag;
	logic signed [dct2d_pkg::COS_W:0]     cos_signed;
	logic signed [dct2d_pkg::ACC_W-1:0]   acc_sum;

	assign busy = (state_q != ST_FILL);
	assign cfg_ready = !busy;

	always_comb begin
		m_sum = {1'b0, m_q} + {1'b0, step_q};
		m_wrap = (m_sum >= FOUR_N) ? (m_sum - FOUR_N) : m_sum;
		k_inc = M_W'(k_q) + M_W'(1);
		if (m_q <= ONE_N) begin
			j_sel = J_W'(m_q);
			neg_sel = 1'b0;
		end else if (m_q < TWO_N) begin
			j_sel = J_W'(TWO_N - m_q);
			neg_sel = 1'b1;
		end else if (m_q < THREE_N) begin
			j_sel = J_W'(m_q - TWO_N);
			neg_sel = 1'b1;
		end else begin
			j_sel = J_W'(FOUR_N - {1'b0, m_q});
			neg_sel = 1'b0;
		end
		cos_mag = dct2d_pkg::COS_ROM[j_sel];
		cos_signed = neg_sel ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
		acc_sum = (tag_s2.first ? '0 : acc_q) + dct2d_pkg::ACC_W'(prod_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			fill_q <= '0;
			k_q <= '0;
			n_q <= '0;
			m_q <= '0;
			step_q <= '0;
			scale_q <= dct2d_pkg::SCALE_RESET;
			tag_s1 <= '0;
			tag_s2 <= '0;
			done_tag_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				scale_q <= cfg_data;
			end
			case (state_q)
				ST_FILL: begin
					if (start) begin
						if (fill_q == LAST_IDX) begin
							fill_q <= '0;
							k_q <= '0;
							n_q <= '0;
							m_q <= '0;
							step_q <= '0;
							state_q <= ST_ISSUE;
						end else begin
							fill_q <= fill_q + K_W'(1);
						end
					end
				end
				ST_ISSUE: begin
					if (n_q == LAST_IDX) begin
						n_q <= '0;
						if (k_q == LAST_IDX) begin
							state_q <= ST_DRAIN;
						end else begin
							k_q <= k_q + K_W'(1);
							m_q <= k_inc;
							step_q <= k_inc << 1;
						end
					end else begin
						n_q <= n_q + K_W'(1);
						m_q <= M_W'(m_wrap);
					end
				end
				ST_DRAIN: begin
					if (coef_valid && last_coef) begin
						state_q <= ST_FILL;
					end
				end
				default: begin
					state_q <= ST_FILL;
				end
			endcase
			tag_s1.valid <= (state_q == ST_ISSUE);
			tag_s1.first <= (n_q == '0);
			tag_s1.last <= (n_q == LAST_IDX);
			tag_s1.index <= dct2d_pkg::coef_index_t'(k_q);
			tag_s2 <= tag_s1;
			done_tag_q.valid <= tag_s2.valid && tag_s2.last;
			done_tag_q.last <= (tag_s2.index == dct2d_pkg::coef_index_t'(LAST_IDX));
			done_tag_q.index <= tag_s2.index;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FILL && start) begin
			store_mem[fill_q] <= sample;
		end
		sample_s1 <= store_mem[n_q];
	end

	always_ff @(posedge clk) begin
		cos_s1 <= cos_signed;
		prod_s2 <= sample_s1 * cos_s1;
		if (tag_s2.valid) begin
			acc_q <= acc_sum;
			if (tag_s2.last) begin
				done_acc_q <= acc_sum;
			end
		end
	end

	dct2d_scale_round u_scale_round (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (done_acc_q),
		.tag         (done_tag_q),
		.scale       (scale_q),
		.coef_valid  (coef_valid),
		.coefficient (coefficient),
		.coef_index  (coef_index),
		.last_coef   (last_coef)
	);

	a_coef_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		coef_valid |-> busy)
		else $error("coefficient strobed while idle");

	a_coef_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		coef_valid && !last_coef |=> !coef_valid)
		else $error("coefficient strobes back to back");

	a_fill_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ISSUE |-> fill_q == '0)
		else $error("fill count not cleared during computation");

	a_busy_holds: assert property (@(posedge clk) disable iff (!arst_n)
		busy && !(coef_valid && last_coef) |=> busy)
		else $error("busy fell before final coefficient");

endmodule

// ===== verif/dct2_direct_1d_checker.sv =====
// ----------------------------------------------------------------------------
// DCT-II coefficient checker
// Watches the sample, gain and coefficient channels of the direct 1-D DCT-II
// block, predicts every coefficient of each completed frame and compares the
// coefficient items in order against those predictions.
// ----------------------------------------------------------------------------
module dct2_direct_1d_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic                                  busy,
	input  logic signed [dct2d_pkg::SAMPLE_W-1:0] sample,
	input  logic                                  cfg_valid,
	input  logic                                  cfg_ready,
	input  logic [dct2d_pkg::SCALE_W-1:0]         cfg_data,
	input  logic                                  coef_valid,
	input  logic signed [dct2d_pkg::COEF_W-1:0]   coefficient,
	input  logic [dct2d_pkg::COEF_INDEX_W-1:0]    coef_index,
	input  logic                                  last_coef,
	output int                                    fail_count,
	output int                                    pending
);

	localparam int FRAME_LENGTH = dct2d_pkg::FRAME_LENGTH;
	localparam longint unsigned PI_Q2_30 = 64'd3373259426;
	localparam longint unsigned ONE_Q2_30 = 64'd1073741824;

	typedef struct {
		logic signed [dct2d_pkg::COEF_W-1:0] coefficient;
		dct2d_pkg::coef_index_t              index;
		logic                                last;
	} coef_expect_t;

	int                                    quarter_cos_q15 [0:FRAME_LENGTH];
	logic signed [dct2d_pkg::SAMPLE_W-1:0] frame_samples [0:FRAME_LENGTH-1];
	int                                    frame_fill;
	logic [dct2d_pkg::SCALE_W-1:0]         gain_q4_12;
	coef_expect_t                          expected_coefs [$];

	// Cosine of pi*j/(2N) in Q1.15 from a nine-term Taylor series in Q2.30.
	function automatic int taylor_cos_q15(int j);
		longint unsigned angle;
		longint unsigned angle_sq;
		longint unsigned term;
		longint signed   series;
		longint signed   rounded;
		angle = (PI_Q2_30 * longint'(j)) / longint'(2 * FRAME_LENGTH);
		angle_sq = (angle * angle) >> 30;
		term = ONE_Q2_30;
		series = longint'(ONE_Q2_30);
		for (int i = 1; i <= 8; i++) begin
			term = ((term * angle_sq) >> 30) / longint'((2 * i - 1) * (2 * i));
			if (i % 2 == 1) begin
				series = series - longint'(term);
			end else begin
				series = series + longint'(term);
			end
		end
		if (series < 0) begin
			series = 0;
		end
		rounded = (series + 16384) / 32768;
		if (rounded > 32767) begin
			rounded = 32767;
		end
		return int'(rounded);
	endfunction

	function automatic int wave_cos_q15(int m);
		if (m <= FRAME_LENGTH) begin
			return quarter_cos_q15[m];
		end else if (m < 2 * FRAME_LENGTH) begin
			return -quarter_cos_q15[2 * FRAME_LENGTH - m];
		end else if (m < 3 * FRAME_LENGTH) begin
			return -quarter_cos_q15[m - 2 * FRAME_LENGTH];
		end
		return quarter_cos_q15[4 * FRAME_LENGTH - m];
	endfunction

	task automatic predict_frame_coefs();
		longint signed dot;
		longint signed scaled;
		longint signed rounded;
		coef_expect_t  coef;
		for (int k = 0; k < FRAME_LENGTH; k++) begin
			dot = 0;
			for (int n = 0; n < FRAME_LENGTH; n++) begin
				dot = dot + longint'(frame_samples[n]) *
					longint'(wave_cos_q15(((2 * n + 1) * k) % (4 * FRAME_LENGTH)));
			end
			scaled = dot * longint'(gain_q4_12);
			rounded = (scaled + 64'sd67108864) >>> 27;
			if (rounded > 64'sd2147483647) begin
				rounded = 64'sd2147483647;
			end else if (rounded < -64'sd2147483648) begin
				rounded = -64'sd2147483648;
			end
			coef.coefficient = rounded[dct2d_pkg::COEF_W-1:0];
			coef.index = dct2d_pkg::COEF_INDEX_W'(k);
			coef.last = (k == FRAME_LENGTH - 1);
			expected_coefs.push_back(coef);
		end
	endtask

	initial begin
		for (int j = 0; j <= FRAME_LENGTH; j++) begin
			quarter_cos_q15[j] = taylor_cos_q15(j);
		end
		fail_count = 0;
		pending = 0;
		frame_fill = 0;
		gain_q4_12 = dct2d_pkg::SCALE_RESET;
	end

	always @(posedge clk or negedge arst_n) begin
		coef_expect_t want;
		if (!arst_n) begin
			frame_fill = 0;
			gain_q4_12 = dct2d_pkg::SCALE_RESET;
			expected_coefs.delete();
		end else begin
			if (coef_valid) begin
				if (expected_coefs.size() == 0) begin
					$error("coefficient item with none expected: index %0d, value %0d",
						coef_index, coefficient);
					fail_count++;
				end else begin
					want = expected_coefs.pop_front();
					if (coefficient !== want.coefficient) begin
						$error("coefficient: expected %0d, actual %0d",
							want.coefficient, coefficient);
						fail_count++;
					end
					if (coef_index !== want.index) begin
						$error("coef_index: expected %0d, actual %0d", want.index, coef_index);
						fail_count++;
					end
					if (last_coef !== want.last) begin
						$error("last_coef: expected %0d, actual %0d", want.last, last_coef);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				gain_q4_12 = cfg_data;
			end
			if (start && !busy) begin
				frame_samples[frame_fill] = sample;
				if (frame_fill == FRAME_LENGTH - 1) begin
					frame_fill = 0;
					predict_frame_coefs();
				end else begin
					frame_fill++;
				end
			end
		end
		pending = expected_coefs.size();
	end

endmodule

// ===== verif/dct2_direct_1d_tb.sv =====
// ----------------------------------------------------------------------------
// DCT-II testbench
// Feeds the direct 1-D DCT-II block with a directed run of fixed edge-case samples
// and then frames of random samples under several gains and idling patterns,
// while a checker beside the block predicts and compares every coefficient.
// ----------------------------------------------------------------------------
module dct2_direct_1d_tb;

	localparam int SAMPLE_W = dct2d_pkg::SAMPLE_W;
	localparam int SCALE_W = dct2d_pkg::SCALE_W;
	localparam int COEF_W = dct2d_pkg::COEF_W;
	localparam int COEF_INDEX_W = dct2d_pkg::COEF_INDEX_W;
	localparam int FRAME_LENGTH = dct2d_pkg::FRAME_LENGTH;

	typedef enum int {
		FRAME_UNIFORM,
		FRAME_EXTREMES,
		FRAME_ALL_MAX,
		FRAME_ALL_MIN,
		FRAME_SMALL
	} frame_kind_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic                       busy;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [SCALE_W-1:0]         cfg_data = '0;
	logic                       coef_valid;
	logic signed [COEF_W-1:0]   coefficient;
	logic [COEF_INDEX_W-1:0]    coef_index;
	logic                       last_coef;
	int                         fail_count;
	int                         pending;

	int                         samples_sent = 0;
	frame_kind_t                frame_kind = FRAME_UNIFORM;
	logic [SAMPLE_W-1:0]        directed_samples [0:23] = '{
		16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF,
		16'h7FFF, 16'h8000, 16'h8000, 16'h5555, 16'hAAAA, 16'h0100,
		16'hFF00, 16'h3039, 16'hCFC7, 16'h0000, 16'h7FFE, 16'h8001,
		16'h4000, 16'hC000, 16'h00FF, 16'hFF01, 16'h7FFF, 16'h8000
	};

	dct2_direct_1d dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.sample     (sample),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.coef_valid (coef_valid),
		.coefficient(coefficient),
		.coef_index (coef_index),
		.last_coef  (last_coef)
	);

	dct2_direct_1d_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.sample     (sample),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.coef_valid (coef_valid),
		.coefficient(coefficient),
		.coef_index (coef_index),
		.last_coef  (last_coef),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_sample(logic [SAMPLE_W-1:0] value, int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			sample <= SAMPLE_W'($urandom);
			@(negedge clk);
		end
		start <= 1'b1;
		sample <= value;
		do begin
			@(posedge clk);
		end while (busy);
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic write_gain(logic [SCALE_W-1:0] gain);
		start <= 1'b0;
		while (pending != 0 || busy) begin
			@(negedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_data <= gain;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample(frame_kind_t kind);
		case (kind)
			FRAME_EXTREMES: begin
				return $urandom_range(1) ? 16'h7FFF : 16'h8000;
			end
			FRAME_ALL_MAX: begin
				return 16'h7FFF;
			end
			FRAME_ALL_MIN: begin
				return 16'h8000;
			end
			FRAME_SMALL: begin
				return SAMPLE_W'($urandom_range(31) - 16);
			end
			default: begin
				return SAMPLE_W'($urandom);
			end
		endcase
	endfunction

	task automatic send_random_samples(int count, int idle_pct);
		int pick;
		for (int i = 0; i < count; i++) begin
			if (samples_sent % FRAME_LENGTH == 0) begin
				pick = $urandom_range(7);
				frame_kind = (pick < 4) ? FRAME_UNIFORM : frame_kind_t'(pick - 3);
			end
			send_sample(pick_sample(frame_kind), idle_pct);
		end
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int i = 0; i < 24; i++) begin
			send_sample(directed_samples[i], 37);
		end
		send_random_samples(40, 37);
		write_gain(16'hFFFF);
		send_random_samples(64, 87);
		write_gain(16'h0000);
		send_random_samples(16, 0);
		write_gain(SCALE_W'($urandom_range(65534, 1)));
		send_random_samples(16, 0);
		start <= 1'b0;
		while (pending != 0 || busy) begin
			@(negedge clk);
		end
		repeat (20) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/dct2d_pkg.sv
sv/dct2d_scale_round.sv
sv/dct2_direct_1d.sv
verif/dct2_direct_1d_checker.sv
verif/dct2_direct_1d_tb.sv
